FILE: rtl/itgd_pkg.sv
// Shared types, constants and helpers for the integer to grouped decimal formatter.
package itgd_pkg;

  // Decimal digit store: enough BCD digits for a 64-bit magnitude
  localparam int NUM_DIGITS = 19;
  localparam int DIG_IDX_W  = 5;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_COMMA = 7'h2C;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture magnitude and sign, clear BCD
    logic shift;       // one double-dabble step
    logic scan;        // locate most significant nonzero digit
    logic emit_sign;   // put out '-'
    logic emit_digit;  // put out digit at current index, step index down
    logic emit_comma;  // put out ','
  } itgd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_last;   // final conversion step this cycle
    logic is_neg;      // captured value was negative
    logic last_digit;  // current digit index is the units digit
    logic need_comma;  // a comma follows the current digit
  } itgd_sts_t;

  // True when a digit position (0..18) is a nonzero multiple of three
  function automatic logic is_group_pos(input logic [DIG_IDX_W-1:0] pos);
    logic hit;
    unique case (pos)
      5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: hit = 1'b1;
      default:                              hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: rtl/itgd_dp.sv
// Datapath: sign/magnitude capture, bit-serial BCD conversion, digit store and character output.
module itgd_dp #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itgd_pkg::itgd_cmd_t    cmd,
  output itgd_pkg::itgd_sts_t    sts,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   cfg_we,
  input  logic                   cfg_group_commas,
  output logic                   out_strobe,
  output logic [6:0]             out_char_code,
  output logic                   out_last_char
);
  import itgd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [3:0]             bcd_r   [NUM_DIGITS];
  logic [3:0]             bcd_nxt [NUM_DIGITS];
  logic [3:0]             bcd_adj [NUM_DIGITS];
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]   idx_r, idx_nxt;
  logic [DIG_IDX_W-1:0]   top_idx;
  logic                   neg_r, neg_nxt;
  logic                   group_r;
  logic [3:0]             cur_digit;

  // Add-3 correction on every digit before the shift
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      bcd_adj[k] = (bcd_r[k] >= 4'd5) ? bcd_r[k] + 4'd3 : bcd_r[k];
    end
  end

  // Most significant nonzero digit; zero when the value is zero
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[k] != 4'd0) top_idx = DIG_IDX_W'(k);
    end
  end

  // Next-state logic
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = in_value[VALUE_WIDTH-1];
      mag_nxt = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
      cnt_nxt = '0;
      for (int k = 0; k < NUM_DIGITS; k++) bcd_nxt[k] = 4'd0;
    end else if (cmd.shift) begin
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      bcd_nxt[0] = {bcd_adj[0][2:0], mag_r[VALUE_WIDTH-1]};
      for (int k = 1; k < NUM_DIGITS; k++) begin
        bcd_nxt[k] = {bcd_adj[k][2:0], bcd_adj[k-1][3]};
      end
    end else if (cmd.scan) begin
      idx_nxt = top_idx;
    end else if (cmd.emit_digit && idx_r != '0) begin
      idx_nxt = idx_r - DIG_IDX_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idx_r   <= '0;
      neg_r   <= 1'b0;
      group_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      neg_r <= neg_nxt;
      if (cfg_we) group_r <= cfg_group_commas;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  // Status
  assign sts.conv_last  = (cnt_r == CNT_LAST);
  assign sts.is_neg     = neg_r;
  assign sts.last_digit = (idx_r == '0);
  assign sts.need_comma = group_r && is_group_pos(idx_r);

  // Character output
  assign cur_digit     = bcd_r[idx_r];
  assign out_strobe    = cmd.emit_sign | cmd.emit_digit | cmd.emit_comma;
  assign out_last_char = cmd.emit_digit && (idx_r == '0);
  always_comb begin
    if (cmd.emit_sign)       out_char_code = CHAR_MINUS;
    else if (cmd.emit_comma) out_char_code = CHAR_COMMA;
    else                     out_char_code = CHAR_ZERO + {3'b000, cur_digit};
  end

endmodule

FILE: rtl/itgd_ctrl.sv
// Controller: sequences capture, conversion, digit scan and character emission.
module itgd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output itgd_pkg::itgd_cmd_t cmd,
  input  itgd_pkg::itgd_sts_t sts
);
  import itgd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_DIG   = 6'b010000,
    ST_COMMA = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Transitions and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = sts.is_neg ? ST_SIGN : ST_DIG;
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_DIG;
      end
      ST_DIG: begin
        cmd.emit_digit = 1'b1;
        if (sts.last_digit)      state_nxt = ST_IDLE;
        else if (sts.need_comma) state_nxt = ST_COMMA;
      end
      ST_COMMA: begin
        cmd.emit_comma = 1'b1;
        state_nxt      = ST_DIG;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_start_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_CONV))
    else $error("accepted transaction did not start conversion");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG && sts.last_digit) |=> (state_r == ST_IDLE))
    else $error("units digit did not end the transaction");
  a_comma_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMA) |=> (state_r == ST_DIG))
    else $error("comma not followed by a digit");
  a_sign_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> sts.is_neg)
    else $error("minus sign for a non-negative value");
`endif

endmodule

FILE: rtl/integer_to_grouped_decimal.sv
// Top level: signed integer to decimal ASCII text with optional thousands commas.
// First character strobes once capture, conversion and digit scan are done.
// One transaction at a time (start taken only when idle), N characters (1..26) each,
//   paced by the one-bit-per-cycle double-dabble conversion and one character per cycle.
// Results strobe for one cycle each; the receiver cannot stall.
// Reset (rst_n low, synchronous): idle, comma grouping on.
module integer_to_grouped_decimal #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_strobe,
  output logic [6:0]                    out_char_code,
  output logic                          out_last_char,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_group_commas
);
  import itgd_pkg::*;

  itgd_cmd_t cmd;
  itgd_sts_t sts;

  // Config register always writable
  assign cfg_ready = 1'b1;

  itgd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  itgd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         ($unsigned(in_value)),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_group_commas (cfg_group_commas),
    .out_strobe       (out_strobe),
    .out_char_code    (out_char_code),
    .out_last_char    (out_last_char)
  );

endmodule
